@@ rtl/core/shsp_pkg.sv @@
// Shared types, constants and helpers for the half-step stepper positioner.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
`default_nettype none

package shsp_pkg;

   // Field and state widths
   localparam int KIND_W  = 2;
   localparam int DEG_W   = 16;
   localparam int COIL_W  = 4;
   localparam int SPT_W   = 13;
   localparam int STEP_W  = 12;
   localparam int ANG_W   = 9;
   localparam int TURN_W  = 20;
   localparam int PHASE_W = 3;
   localparam int QUO_W   = 8;
   localparam int PROD_W  = 21;
   localparam int MODC_W  = 4;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Motor constants
   localparam int MAX_STEPS_PER_TURN = 4096;
   localparam int PHASES_PER_STEP    = 8;
   localparam int DEG_PER_TURN       = 360;
   localparam logic [SPT_W-1:0] SPT_RESET = 13'd512;

   // Reciprocals of 360: quotient of a 16-bit degree value (shift 24) and
   // the goal step scaling of a 21-bit product (shift 29); both exact over their range
   localparam logic [15:0] RECIP_DEG  = 16'd46604;
   localparam int          RECIP_DEG_SH = 24;
   localparam logic [20:0] RECIP_GOAL = 21'd1491309;
   localparam int          RECIP_GOAL_SH = 29;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ABS  = 2'd2;

   // Register map: register index is address bit 2
   localparam logic REG_STEPS_PER_TURN = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUO,
      ST_REM,
      ST_ANG,
      ST_PROD,
      ST_GOAL,
      ST_MOD,
      ST_FULL,
      ST_SEEK
   } ctl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_cmd;
      logic load_rel;
      logic quo;
      logic rem;
      logic ang;
      logic prod;
      logic goal;
      logic mod_step;
      logic full_step;
      logic seek_step;
      logic finish;
      logic pattern;
      logic ignore;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cmd_rel;
      logic phase_zero;
      logic left_zero;
      logic at_goal;
      logic mod_last;
      logic out_free;
      logic out_valid;
   } dp_stat_type;

   // Half-step coil sequence
   function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] idx);
      logic [COIL_W-1:0] pat;
      case (idx)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/shsp_if.sv @@
// Valid/ready channel interfaces for command/tick items and coil results.
// Depends on shsp_pkg for field widths.
`default_nettype none

interface shsp_req_if;
   logic                               valid;
   logic                               ready;
   logic [shsp_pkg::KIND_W-1:0]        kind;
   logic signed [shsp_pkg::DEG_W-1:0]  rel_degrees;
   logic [shsp_pkg::DEG_W-1:0]         abs_degrees;

   modport source (output valid, output kind, output rel_degrees, output abs_degrees,
                   input ready);
   modport sink   (input valid, input kind, input rel_degrees, input abs_degrees,
                   output ready);
endinterface

interface shsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [shsp_pkg::COIL_W-1:0]   coils;
   logic                          moving;
   logic                          done_res;
   logic                          ignored;

   modport source (output valid, output coils, output moving, output done_res,
                   output ignored, input ready);
   modport sink   (input valid, input coils, input moving, input done_res,
                   input ignored, output ready);
endinterface

`default_nettype wire

@@ rtl/core/shsp_dp.sv @@
// Datapath of the positioner: command scaling, step index arithmetic, phase
// counter and result register. Depends on shsp_pkg; driven by shsp_ctrl.
`default_nettype none

module shsp_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire shsp_pkg::ctl_cmd_type             cmd,
   input  wire logic [shsp_pkg::SPT_W-1:0]        spt_cfg,
   input  wire logic signed [shsp_pkg::DEG_W-1:0] rel_degrees,
   input  wire logic [shsp_pkg::DEG_W-1:0]        abs_degrees,
   input  wire logic                              rsp_ready,
   output shsp_pkg::dp_stat_type                  stat,
   output logic                                   rsp_valid,
   output logic [shsp_pkg::COIL_W-1:0]            rsp_coils,
   output logic                                   rsp_moving,
   output logic                                   rsp_done_res,
   output logic                                   rsp_ignored
);

   // Control-relevant state (reset)
   logic [shsp_pkg::SPT_W-1:0]   run_spt_ff, run_spt_in;
   logic [shsp_pkg::STEP_W-1:0]  step_index_ff, step_index_in;
   logic [shsp_pkg::STEP_W-1:0]  step_red_ff, step_red_in;
   logic [shsp_pkg::ANG_W-1:0]   angle_now_ff, angle_now_in;
   logic [shsp_pkg::STEP_W-1:0]  goal_step_ff, goal_step_in;
   logic [shsp_pkg::ANG_W-1:0]   goal_angle_ff, goal_angle_in;
   logic [shsp_pkg::TURN_W-1:0]  turns_left_ff, turns_left_in;
   logic                         bw_ff, bw_in;
   logic [shsp_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                         rel_ff, rel_in;
   logic                         out_valid_ff, out_valid_in;

   // Working registers of the command setup (no reset)
   logic                          neg_ff, neg_in;
   logic [shsp_pkg::DEG_W-1:0]    x_ff, x_in;
   logic [shsp_pkg::QUO_W-1:0]    q_ff, q_in;
   logic [shsp_pkg::ANG_W-1:0]    rem_ff, rem_in;
   logic [shsp_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [shsp_pkg::STEP_W-1:0]   mod_acc_ff, mod_acc_in;
   logic [shsp_pkg::MODC_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic [shsp_pkg::COIL_W-1:0]   coils_ff, coils_in;
   logic                          moving_ff, moving_in;
   logic                          done_ff, done_in;
   logic                          ign_ff, ign_in;

   // Combinational helpers
   logic [shsp_pkg::SPT_W-1:0]   spt_eff;
   logic [shsp_pkg::DEG_W-1:0]   raw_deg;
   logic [shsp_pkg::DEG_W-1:0]   mag_deg;
   logic [31:0]                  quo_prod;
   logic [16:0]                  q_times_deg;
   logic [16:0]                  rem_full;
   logic [20:0]                  turn_prod;
   logic [9:0]                   ang_sum;
   logic [9:0]                   ang_red;
   logic [21:0]                  ga_prod;
   logic [41:0]                  gs_prod;
   logic [12:0]                  mod_sh;
   logic [12:0]                  mod_sub;
   logic [shsp_pkg::STEP_W-1:0]  mod_next;
   logic [shsp_pkg::STEP_W-1:0]  half_spt;
   logic [shsp_pkg::STEP_W-1:0]  spt_m1;
   logic                         seek_back;
   logic                         move_dir;
   logic [shsp_pkg::STEP_W-1:0]  moved;
   logic                         pat_dir;
   logic [shsp_pkg::PHASE_W-1:0] pat_idx;
   logic                         emit;

   // Clamp the configured step count into 1..MAX
   always_comb begin
      if (spt_cfg == '0) begin
         spt_eff = shsp_pkg::SPT_W'(1);
      end else if (spt_cfg > shsp_pkg::SPT_W'(shsp_pkg::MAX_STEPS_PER_TURN)) begin
         spt_eff = shsp_pkg::SPT_W'(shsp_pkg::MAX_STEPS_PER_TURN);
      end else begin
         spt_eff = spt_cfg;
      end
   end

   // Magnitude of the relative turn
   assign raw_deg = $unsigned(rel_degrees);
   assign mag_deg = raw_deg[shsp_pkg::DEG_W-1] ? (~raw_deg + 16'd1) : raw_deg;

   // Setup arithmetic, one multiply per stage
   assign quo_prod    = 32'(x_ff) * 32'(shsp_pkg::RECIP_DEG);
   assign q_times_deg = 17'(q_ff) * 17'(shsp_pkg::DEG_PER_TURN);
   assign rem_full    = 17'(x_ff) - q_times_deg;
   assign turn_prod   = 21'(q_ff) * 21'(run_spt_ff);

   always_comb begin
      if (!rel_ff) begin
         ang_sum = 10'(rem_ff);
      end else if (neg_ff) begin
         ang_sum = 10'(angle_now_ff) + 10'(shsp_pkg::DEG_PER_TURN) - 10'(rem_ff);
      end else begin
         ang_sum = 10'(angle_now_ff) + 10'(rem_ff);
      end
   end
   assign ang_red = (ang_sum >= 10'(shsp_pkg::DEG_PER_TURN)) ?
                    (ang_sum - 10'(shsp_pkg::DEG_PER_TURN)) : ang_sum;

   assign ga_prod = 22'(goal_angle_ff) * 22'(run_spt_ff);
   assign gs_prod = 42'(prod_ff) * 42'(shsp_pkg::RECIP_GOAL);

   // Restoring remainder of the step index by the step count, one bit a cycle
   assign mod_sh   = {mod_acc_ff, step_index_ff[mod_cnt_ff]};
   assign mod_sub  = mod_sh - run_spt_ff;
   assign mod_next = (mod_sh >= run_spt_ff) ? mod_sub[shsp_pkg::STEP_W-1:0]
                                            : mod_sh[shsp_pkg::STEP_W-1:0];

   // Shorter-way decision and one step move on the reduced index
   assign half_spt = run_spt_ff[shsp_pkg::SPT_W-1:1];
   assign spt_m1   = shsp_pkg::STEP_W'(run_spt_ff - 13'd1);
   assign seek_back = ((step_index_ff > goal_step_ff) &&
                       ((step_index_ff - goal_step_ff) < half_spt)) ||
                      ((step_index_ff < goal_step_ff) &&
                       ((goal_step_ff - step_index_ff) > half_spt));
   assign move_dir = cmd.seek_step ? seek_back : bw_ff;

   always_comb begin
      if (move_dir) begin
         moved = (step_red_ff == '0) ? spt_m1 : (step_red_ff - 12'd1);
      end else if ((13'(step_red_ff) + 13'd1) == run_spt_ff) begin
         moved = '0;
      end else begin
         moved = step_red_ff + 12'd1;
      end
   end

   // Pattern index, reversed when going backward
   assign pat_dir = cmd.seek_step ? seek_back : bw_ff;
   assign pat_idx = pat_dir ? (shsp_pkg::PHASE_W'(shsp_pkg::PHASES_PER_STEP - 1) - phase_ff)
                            : phase_ff;
   assign emit    = cmd.finish | cmd.pattern | cmd.ignore;

   // Next-state logic
   always_comb begin
      run_spt_in    = run_spt_ff;
      step_index_in = step_index_ff;
      step_red_in   = step_red_ff;
      angle_now_in  = angle_now_ff;
      goal_step_in  = goal_step_ff;
      goal_angle_in = goal_angle_ff;
      turns_left_in = turns_left_ff;
      bw_in         = bw_ff;
      phase_in      = phase_ff;
      rel_in        = rel_ff;
      neg_in        = neg_ff;
      x_in          = x_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      prod_in       = prod_ff;
      mod_acc_in    = mod_acc_ff;
      mod_cnt_in    = mod_cnt_ff;
      coils_in      = coils_ff;
      moving_in     = moving_ff;
      done_in       = done_ff;
      ign_in        = ign_ff;

      // Latch a new command
      if (cmd.load_cmd) begin
         run_spt_in = spt_eff;
         rel_in     = cmd.load_rel;
         neg_in     = cmd.load_rel & raw_deg[shsp_pkg::DEG_W-1];
         x_in       = cmd.load_rel ? mag_deg : abs_degrees;
         if (cmd.load_rel) begin
            bw_in = raw_deg[shsp_pkg::DEG_W-1];
         end
         phase_in   = '0;
         mod_acc_in = '0;
         mod_cnt_in = shsp_pkg::MODC_W'(shsp_pkg::STEP_W - 1);
      end

      // Setup stages
      if (cmd.quo) begin
         q_in = quo_prod[shsp_pkg::RECIP_DEG_SH +: shsp_pkg::QUO_W];
      end
      if (cmd.rem) begin
         rem_in        = rem_full[shsp_pkg::ANG_W-1:0];
         turns_left_in = rel_ff ? turn_prod[shsp_pkg::TURN_W-1:0] : '0;
      end
      if (cmd.ang) begin
         goal_angle_in = ang_red[shsp_pkg::ANG_W-1:0];
      end
      if (cmd.prod) begin
         prod_in = ga_prod[shsp_pkg::PROD_W-1:0];
      end
      if (cmd.goal) begin
         goal_step_in = gs_prod[shsp_pkg::RECIP_GOAL_SH +: shsp_pkg::STEP_W];
      end
      if (cmd.mod_step) begin
         mod_acc_in = mod_next;
         mod_cnt_in = mod_cnt_ff - 4'd1;
         if (mod_cnt_ff == '0) begin
            step_red_in = mod_next;
         end
      end

      // Motion steps
      if (cmd.full_step) begin
         turns_left_in = turns_left_ff - 20'd1;
      end
      if (cmd.full_step || cmd.seek_step) begin
         step_index_in = moved;
         step_red_in   = moved;
      end
      if (cmd.seek_step) begin
         bw_in = seek_back;
      end
      if (cmd.finish) begin
         angle_now_in = goal_angle_ff;
         bw_in        = 1'b0;
      end
      if (cmd.pattern) begin
         phase_in = phase_ff + 3'd1;
      end

      // Result fields
      if (emit) begin
         coils_in  = cmd.pattern ? shsp_pkg::coil_pattern(pat_idx) : '0;
         moving_in = cmd.pattern;
         done_in   = cmd.finish;
         ign_in    = cmd.ignore;
      end
   end

   // Hold the result until it is taken
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_spt_ff    <= shsp_pkg::SPT_RESET;
         step_index_ff <= '0;
         step_red_ff   <= '0;
         angle_now_ff  <= '0;
         goal_step_ff  <= '0;
         goal_angle_ff <= '0;
         turns_left_ff <= '0;
         bw_ff         <= 1'b0;
         phase_ff      <= '0;
         rel_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         run_spt_ff    <= run_spt_in;
         step_index_ff <= step_index_in;
         step_red_ff   <= step_red_in;
         angle_now_ff  <= angle_now_in;
         goal_step_ff  <= goal_step_in;
         goal_angle_ff <= goal_angle_in;
         turns_left_ff <= turns_left_in;
         bw_ff         <= bw_in;
         phase_ff      <= phase_in;
         rel_ff        <= rel_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      x_ff       <= x_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      prod_ff    <= prod_in;
      mod_acc_ff <= mod_acc_in;
      mod_cnt_ff <= mod_cnt_in;
      coils_ff   <= coils_in;
      moving_ff  <= moving_in;
      done_ff    <= done_in;
      ign_ff     <= ign_in;
   end

   // Status towards the controller
   assign stat.cmd_rel    = rel_ff;
   assign stat.phase_zero = (phase_ff == '0);
   assign stat.left_zero  = (turns_left_ff == '0);
   assign stat.at_goal    = (step_index_ff == goal_step_ff);
   assign stat.mod_last   = (mod_cnt_ff == '0);
   assign stat.out_free   = !out_valid_ff || rsp_ready;
   assign stat.out_valid  = out_valid_ff;

   assign rsp_valid    = out_valid_ff;
   assign rsp_coils    = coils_ff;
   assign rsp_moving   = moving_ff;
   assign rsp_done_res = done_ff;
   assign rsp_ignored  = ign_ff;

endmodule

`default_nettype wire

@@ rtl/core/shsp_ctrl.sv @@
// Controller of the positioner: command setup sequence, full-turn and seek
// motion states, input handshake. Depends on shsp_pkg; drives shsp_dp.
`default_nettype none

module shsp_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [shsp_pkg::KIND_W-1:0] req_kind,
   input  wire shsp_pkg::dp_stat_type       stat,
   output logic                             req_ready,
   output shsp_pkg::ctl_cmd_type            cmd
);

   shsp_pkg::ctl_state_type state_ff, state_in;

   logic motion;
   logic req_fire;
   logic is_cmd;
   logic is_tick;

   assign motion  = (state_ff == shsp_pkg::ST_FULL) || (state_ff == shsp_pkg::ST_SEEK);
   assign is_cmd  = (req_kind == shsp_pkg::KIND_REL) || (req_kind == shsp_pkg::KIND_ABS);
   assign is_tick = (req_kind == shsp_pkg::KIND_TICK);

   // Take items only outside the setup sequence and with room for a result
   assign req_ready = ((state_ff == shsp_pkg::ST_IDLE) || motion) && stat.out_free;
   assign req_fire  = req_valid && req_ready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         shsp_pkg::ST_IDLE: begin
            if (req_fire && is_cmd) begin
               cmd.load_cmd = 1'b1;
               cmd.load_rel = (req_kind == shsp_pkg::KIND_REL);
               state_in     = shsp_pkg::ST_QUO;
            end
         end
         shsp_pkg::ST_QUO: begin
            cmd.quo  = 1'b1;
            state_in = shsp_pkg::ST_REM;
         end
         shsp_pkg::ST_REM: begin
            cmd.rem  = 1'b1;
            state_in = shsp_pkg::ST_ANG;
         end
         shsp_pkg::ST_ANG: begin
            cmd.ang  = 1'b1;
            state_in = shsp_pkg::ST_PROD;
         end
         shsp_pkg::ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = shsp_pkg::ST_GOAL;
         end
         shsp_pkg::ST_GOAL: begin
            cmd.goal = 1'b1;
            state_in = shsp_pkg::ST_MOD;
         end
         shsp_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               state_in = stat.cmd_rel ? shsp_pkg::ST_FULL : shsp_pkg::ST_SEEK;
            end
         end
         shsp_pkg::ST_FULL: begin
            if (req_fire && is_cmd) begin
               cmd.ignore = 1'b1;
            end else if (req_fire && is_tick) begin
               if (stat.phase_zero && stat.left_zero) begin
                  // whole turns done: seek the remainder in this same tick
                  if (stat.at_goal) begin
                     cmd.finish = 1'b1;
                     state_in   = shsp_pkg::ST_IDLE;
                  end else begin
                     cmd.seek_step = 1'b1;
                     cmd.pattern   = 1'b1;
                     state_in      = shsp_pkg::ST_SEEK;
                  end
               end else if (stat.phase_zero) begin
                  cmd.full_step = 1'b1;
                  cmd.pattern   = 1'b1;
               end else begin
                  cmd.pattern = 1'b1;
               end
            end
         end
         shsp_pkg::ST_SEEK: begin
            if (req_fire && is_cmd) begin
               cmd.ignore = 1'b1;
            end else if (req_fire && is_tick) begin
               if (stat.phase_zero && stat.at_goal) begin
                  cmd.finish = 1'b1;
                  state_in   = shsp_pkg::ST_IDLE;
               end else if (stat.phase_zero) begin
                  cmd.seek_step = 1'b1;
                  cmd.pattern   = 1'b1;
               end else begin
                  cmd.pattern = 1'b1;
               end
            end
         end
         default: begin
            state_in = shsp_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A step is only ever part way through while a motion runs
   a_phase_in_motion: assert property (@(posedge clock) disable iff (reset)
      !stat.phase_zero |-> motion)
      else $error("half-step phase advanced outside a motion");

   // A command taken during a motion produces a flagged result
   a_busy_cmd_flagged: assert property (@(posedge clock) disable iff (reset)
      (req_fire && motion && is_cmd) |=> stat.out_valid)
      else $error("command during motion produced no result");

   // A command taken while idle starts the setup sequence
   a_setup_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == shsp_pkg::ST_IDLE && req_fire && is_cmd) |=>
      (state_ff == shsp_pkg::ST_QUO))
      else $error("accepted command did not start setup");

   // The remainder pass always hands over to a motion state
   a_mod_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == shsp_pkg::ST_MOD && stat.mod_last) |=>
      (state_ff == shsp_pkg::ST_FULL || state_ff == shsp_pkg::ST_SEEK))
      else $error("setup did not enter a motion state");
`endif

endmodule

`default_nettype wire

@@ rtl/core/stepper_half_step_positioner_unit.sv @@
// Top level of the half-step stepper positioner: APB register, controller and datapath.
// Depends on shsp_pkg, shsp_if (channel interfaces), shsp_ctrl and shsp_dp.
`default_nettype none

// Drives a four-coil stepper in half steps. Commands (relative turn or absolute
// angle) are scaled in a setup sequence: five arithmetic stages (reciprocal
// quotient by 360, remainder and full-turn count, goal angle, angle times step
// count, goal step) and a bit-serial remainder of the current step index by the
// step count. No item is taken during setup. During a motion a tick yields one
// coil pattern and a command yields a result flagged ignored. One result register
// sits on the output; outside setup an item is taken while that register is empty
// or being read, and is held back only when it is full and not being read.
// steps_per_turn sits at byte address 0 and is latched when a command is taken.
module stepper_half_step_positioner_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   shsp_req_if.sink                           req_chan,
   shsp_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [shsp_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [shsp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [shsp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready
);

   logic [shsp_pkg::SPT_W-1:0] spt_ff, spt_in;
   logic                       csr_wr;

   shsp_pkg::ctl_cmd_type cmd;
   shsp_pkg::dp_stat_type stat;

   // Register write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      spt_in = spt_ff;
      if (csr_wr && (csr_paddr[2] == shsp_pkg::REG_STEPS_PER_TURN)) begin
         spt_in = csr_pwdata[shsp_pkg::SPT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff <= shsp_pkg::SPT_RESET;
      end else begin
         spt_ff <= spt_in;
      end
   end

   // Read back
   assign csr_prdata = (csr_paddr[2] == shsp_pkg::REG_STEPS_PER_TURN) ?
                       shsp_pkg::CSR_DW'(spt_ff) : '0;

   shsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .stat      (stat),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   shsp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .spt_cfg      (spt_ff),
      .rel_degrees  (req_chan.rel_degrees),
      .abs_degrees  (req_chan.abs_degrees),
      .rsp_ready    (rsp_chan.ready),
      .stat         (stat),
      .rsp_valid    (rsp_chan.valid),
      .rsp_coils    (rsp_chan.coils),
      .rsp_moving   (rsp_chan.moving),
      .rsp_done_res (rsp_chan.done_res),
      .rsp_ignored  (rsp_chan.ignored)
   );

endmodule

`default_nettype wire

@@ verif/stepper_half_step_positioner_unit_tb.sv @@
// Self-checking testbench for stepper_half_step_positioner_unit: valid/ready
// stimulus, APB writes of steps_per_turn and a transfer-level motor predictor.
// Depends on shsp_pkg, shsp_if and the RTL of the positioner.
`timescale 1ns / 100ps

module stepper_half_step_positioner_unit_tb;
   import shsp_pkg::*;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam logic [CSR_AW-1:0] STEPS_ADDR = {REG_STEPS_PER_TURN, 2'b00};
   localparam logic [COIL_W-1:0] HALF_STEP_SEQ [8] =
      '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400_000;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DEG_W-1:0]  rel_deg;
      logic [DEG_W-1:0]         abs_deg;
   } motor_item_t;

   typedef struct packed {
      logic [COIL_W-1:0] coils;
      logic              moving;
      logic              done_res;
      logic              ignored;
   } coil_res_t;

   typedef struct {
      logic [STEP_W-1:0]  step_idx;
      logic [ANG_W-1:0]   angle;
      logic [STEP_W-1:0]  goal_step;
      logic [ANG_W-1:0]   goal_angle;
      logic [TURN_W-1:0]  turn_left;
      bit                 backward;
      logic [PHASE_W-1:0] phase;
      ctl_state_type      mode;
      logic [SPT_W-1:0]   run_spt;
   } motor_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              feed_valid = 1'b0;
   motor_item_t       feed_item = '0;
   logic              take_ready = 1'b0;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   shsp_req_if req_chan ();
   shsp_rsp_if rsp_chan ();

   assign req_chan.valid       = feed_valid;
   assign req_chan.kind        = feed_item.kind;
   assign req_chan.rel_degrees = feed_item.rel_deg;
   assign req_chan.abs_degrees = feed_item.abs_deg;
   assign rsp_chan.ready       = take_ready;

   stepper_half_step_positioner_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   motor_item_t motor_items_q [$];
   coil_res_t   coil_results_q [$];
   motor_t      motor;
   motor_t      plan_motor;
   coil_res_t   predicted;
   coil_res_t   oldest;
   logic [SPT_W-1:0] csr_steps;
   int unsigned planned_items;
   int          send_idle_pct = 15;
   int          recv_idle_pct = 62;
   int          calm_left = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Step count in use: zero acts as one, large values clamp to the maximum
   function automatic int unsigned eff_steps(input logic [SPT_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_STEPS_PER_TURN) return MAX_STEPS_PER_TURN;
      return v;
   endfunction

   function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s,
                                                   input bit back, input int unsigned spt);
      if (back) return STEP_W'((s + spt - 1) % spt);
      return STEP_W'((s + 1) % spt);
   endfunction

   function automatic motor_t motor_at_reset();
      motor_t m;
      m.step_idx   = '0;
      m.angle      = '0;
      m.goal_step  = '0;
      m.goal_angle = '0;
      m.turn_left  = '0;
      m.backward   = 1'b0;
      m.phase      = '0;
      m.mode       = ST_IDLE;
      m.run_spt    = SPT_RESET;
      return m;
   endfunction

   // Apply one item to the motor state; returns 1 when a result comes out
   function automatic bit advance_motor(inout motor_t m, input motor_item_t it,
                                        input logic [SPT_W-1:0] steps_reg,
                                        output coil_res_t r);
      int unsigned spt, mag, rem, half;
      logic [DEG_W-1:0] raw;
      bit back;
      r = '0;
      if (it.kind == KIND_NONE) return 0;
      if (it.kind == KIND_REL || it.kind == KIND_ABS) begin
         if (m.mode != ST_IDLE) begin
            r.ignored = 1'b1;
            return 1;
         end
         m.run_spt = SPT_W'(eff_steps(steps_reg));
         spt = m.run_spt;
         if (it.kind == KIND_REL) begin
            raw = it.rel_deg;
            mag = raw[DEG_W-1] ? 32'h10000 - raw : raw;
            rem = mag % 360;
            m.turn_left = TURN_W'((mag / 360) * spt);
            m.backward = raw[DEG_W-1];
            if (raw[DEG_W-1]) m.goal_angle = ANG_W'((m.angle + 360 - rem) % 360);
            else m.goal_angle = ANG_W'((m.angle + rem) % 360);
            m.mode = ST_FULL;
         end else begin
            m.goal_angle = ANG_W'(it.abs_deg % 360);
            m.turn_left = '0;
            m.mode = ST_SEEK;
         end
         m.goal_step = STEP_W'((m.goal_angle * spt / 360) % spt);
         m.phase = '0;
         return 0;
      end
      // tick
      if (m.mode != ST_FULL && m.mode != ST_SEEK) return 0;
      spt = m.run_spt;
      if (m.phase == 0) begin
         if (m.mode == ST_FULL) begin
            if (m.turn_left == 0) begin
               m.mode = ST_SEEK;
            end else begin
               m.turn_left = m.turn_left - 1'b1;
               m.step_idx = next_step(m.step_idx, m.backward, spt);
            end
         end
         if (m.mode == ST_SEEK) begin
            half = spt / 2;
            if (m.step_idx == m.goal_step) begin
               m.angle = m.goal_angle;
               m.mode = ST_IDLE;
               m.backward = 1'b0;
               r.done_res = 1'b1;
               return 1;
            end
            // shorter way round; an exact half turn goes forward
            back = (m.step_idx > m.goal_step && m.step_idx - m.goal_step < half) ||
                   (m.step_idx < m.goal_step && m.goal_step - m.step_idx > half);
            m.backward = back;
            m.step_idx = next_step(m.step_idx, m.backward, spt);
         end
      end
      r.coils = HALF_STEP_SEQ[m.backward ? 3'd7 - m.phase : m.phase];
      r.moving = 1'b1;
      m.phase = m.phase + 1'b1;
      return 1;
   endfunction

   // Queue one item and run it through the planning copy of the motor
   function automatic void queue_item(input logic [KIND_W-1:0] kind,
                                      input logic signed [DEG_W-1:0] rel,
                                      input logic [DEG_W-1:0] absd);
      motor_item_t it;
      coil_res_t r;
      bit has;
      it.kind = kind;
      it.rel_deg = rel;
      it.abs_deg = absd;
      motor_items_q.push_back(it);
      has = advance_motor(plan_motor, it, csr_steps, r);
      if (has || kind == KIND_REL || kind == KIND_ABS) planned_items++;
   endfunction

   function automatic void queue_tick();
      queue_item(KIND_TICK, DEG_W'($urandom), DEG_W'($urandom));
   endfunction

   // Tick until the planned motion has ended
   function automatic void run_out(input int cap);
      while (plan_motor.mode != ST_IDLE && cap > 0) begin
         queue_tick();
         cap--;
      end
   endfunction

   // Largest turn in degrees that keeps a motion to about a dozen steps
   function automatic int unsigned turn_span();
      int unsigned s;
      s = 12 * 360 / eff_steps(csr_steps);
      if (s < 1) s = 1;
      if (s > 32768) s = 32768;
      return s;
   endfunction

   function automatic void queue_rel();
      int unsigned mag;
      bit neg;
      int val;
      mag = $urandom_range(0, turn_span());
      neg = $urandom_range(0, 1);
      if (!neg && mag > 32767) mag = 32767;
      val = neg ? -int'(mag) : int'(mag);
      queue_item(KIND_REL, DEG_W'(val), DEG_W'($urandom));
   endfunction

   // Absolute target near the current step, folded up by whole turns of degrees
   function automatic void queue_abs();
      int unsigned spt, base, d, target, k, span;
      spt = eff_steps(csr_steps);
      base = (plan_motor.step_idx % spt) * 360 / spt;
      span = turn_span();
      d = $urandom_range(0, span > 179 ? 179 : span);
      target = $urandom_range(0, 1) ? (base + d) % 360 : (base + 360 - d) % 360;
      k = $urandom_range(0, (65535 - target) / 360);
      queue_item(KIND_ABS, DEG_W'($urandom), DEG_W'(target + 360 * k));
   endfunction

   function automatic void queue_command();
      if ($urandom_range(0, 1)) queue_rel();
      else queue_abs();
   endfunction

   // Mostly complete motions with random content, plus noise and cut-short motions
   function automatic void queue_random(input int unsigned n);
      int unsigned pick;
      int cap;
      queue_abs();
      run_out(5000);
      while (planned_items < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            queue_command();
            cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : 5000;
            while (plan_motor.mode != ST_IDLE && cap > 0) begin
               if ($urandom_range(0, 39) == 0) queue_command();
               queue_tick();
               cap--;
            end
            if (plan_motor.mode == ST_IDLE && $urandom_range(0, 3) == 0) queue_tick();
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 4)) queue_tick();
         end else if (pick < 90) begin
            queue_item(KIND_NONE, DEG_W'($urandom), DEG_W'($urandom));
         end else begin
            queue_command();
         end
      end
      run_out(5000);
   endfunction

   // Hold until every item is transferred and every result has arrived
   task automatic wait_quiet();
      while (motor_items_q.size() != 0 || feed_valid || coil_results_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_steps(input logic [SPT_W-1:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= STEPS_ADDR;
      csr_pwdata  <= {CSR_DW'($urandom) >> SPT_W << SPT_W} | CSR_DW'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_steps = v;
   endtask

   task automatic start_phase(input int send_pct, input int recv_pct,
                              input logic [SPT_W-1:0] steps);
      wait_quiet();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_steps(steps);
      plan_motor = motor;
      planned_items = 0;
   endtask

   // Random stretches with no idling on either side
   always @(posedge clock) begin
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(20, 80);
   end

   // Driver: offer the next item once the previous transfer is done
   always @(posedge clock) begin
      if (reset) begin
         feed_valid <= 1'b0;
      end else if (!feed_valid || req_chan.ready) begin
         if (motor_items_q.size() != 0 &&
             (calm_left != 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
            feed_item  <= motor_items_q.pop_front();
            feed_valid <= 1'b1;
         end else begin
            feed_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         take_ready <= calm_left != 0 || $urandom_range(0, 99) >= recv_idle_pct;
         if (feed_valid && req_chan.ready) begin
            if (advance_motor(motor, feed_item, csr_steps, predicted))
               coil_results_q.push_back(predicted);
         end
         if (rsp_chan.valid && take_ready) begin
            if (coil_results_q.size() == 0) begin
               $error("unpredicted result: coils %h moving %b done_res %b ignored %b",
                      rsp_chan.coils, rsp_chan.moving, rsp_chan.done_res, rsp_chan.ignored);
               mismatches++;
            end else begin
               oldest = coil_results_q.pop_front();
               if (rsp_chan.coils !== oldest.coils) begin
                  $error("coils: expected %h, got %h", oldest.coils, rsp_chan.coils);
                  mismatches++;
               end
               if (rsp_chan.moving !== oldest.moving) begin
                  $error("moving: expected %b, got %b", oldest.moving, rsp_chan.moving);
                  mismatches++;
               end
               if (rsp_chan.done_res !== oldest.done_res) begin
                  $error("done_res: expected %b, got %b", oldest.done_res, rsp_chan.done_res);
                  mismatches++;
               end
               if (rsp_chan.ignored !== oldest.ignored) begin
                  $error("ignored: expected %b, got %b", oldest.ignored, rsp_chan.ignored);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      motor = motor_at_reset();
      csr_steps = SPT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      plan_motor = motor;

      // Reset step count: idle tick, unused kind, zero-length move, busy commands,
      // small backward turn and zero turn
      queue_tick();
      queue_item(KIND_NONE, 16'shFFFF, 16'hFFFF);
      queue_item(KIND_ABS, 16'sh0000, 16'h0000);
      run_out(5000);
      queue_item(KIND_ABS, 16'sh8000, 16'hFFFF);
      repeat (3) queue_tick();
      queue_item(KIND_ABS, 16'sh0000, 16'h0000);
      queue_item(KIND_REL, 16'sh7FFF, 16'h0000);
      run_out(5000);
      queue_item(KIND_REL, -16'sd1, 16'h0000);
      run_out(5000);
      queue_item(KIND_REL, 16'sd0, 16'hFFFF);
      run_out(5000);

      // Step count zero acts as one: wrapped absolute angle and a backward whole turn
      start_phase(15, 62, 13'd0);
      queue_item(KIND_ABS, 16'sh0000, 16'hFFFF);
      run_out(5000);
      queue_item(KIND_REL, -16'sd360, 16'h0000);
      run_out(5000);

      // Out-of-range step count clamps to the maximum
      start_phase(15, 62, 13'h1FFF);
      queue_item(KIND_ABS, 16'sh0000, 16'd1);
      run_out(5000);
      queue_item(KIND_REL, -16'sd1, 16'h0000);
      run_out(5000);

      // Four steps per turn: ties at exactly half a turn go forward
      start_phase(15, 62, 13'd4);
      queue_item(KIND_ABS, 16'sh0000, 16'd180);
      run_out(5000);
      queue_item(KIND_ABS, 16'sh0000, 16'd0);
      run_out(5000);
      queue_item(KIND_REL, 16'sd370, 16'h0000);
      run_out(5000);

      // Random phases across step counts and idling patterns
      start_phase(15, 62, SPT_W'($urandom_range(1, 40)));
      queue_random(150);
      start_phase(62, 15, SPT_W'($urandom_range(41, 4095)));
      queue_random(150);
      start_phase(0, 0, SPT_W'(MAX_STEPS_PER_TURN));
      queue_random(110);

      // Most negative turn at one step per turn: start the full-turn run, offer a busy command, then stop
      start_phase(0, 0, 13'd0);
      queue_item(KIND_REL, 16'sh8000, 16'h0000);
      repeat (60) queue_tick();
      queue_item(KIND_REL, 16'sh7FFF, 16'h0000);
      repeat (4) queue_tick();

      wait_quiet();
      if (mismatches == 0 && coil_results_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
